// ===== hw/rtl/euc_to_unicode_decoder_defines.svh =====
// Assertion macros for the EUC to Unicode decoder.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef EUC_TO_UNICODE_DECODER_DEFINES_SVH
`define EUC_TO_UNICODE_DECODER_DEFINES_SVH

`ifndef SYNTH
`define E2U_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("e2u check failed");
`define E2U_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("e2u check failed");
`else
`define E2U_ASSERT(label, clk, rst_n, ante, cons)
`define E2U_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/e2u_pkg.sv =====
// Shared types and constants of the EUC to Unicode decoder.
// No dependencies.
`timescale 1ns / 1ps
package e2u_pkg;
	localparam logic [1:0] OP_FLAG   = 2'd0;
	localparam logic [1:0] OP_MAP    = 2'd1;
	localparam logic [1:0] OP_DECODE = 2'd2;

	localparam logic [1:0] K_CHAR     = 2'd0;
	localparam logic [1:0] K_TERM     = 2'd1;
	localparam logic [1:0] K_TERM_MAP = 2'd2;

	localparam logic [7:0]  KANA_FIRST = 8'ha0;
	localparam logic [7:0]  KANA_END   = 8'he0;
	localparam logic [15:0] KANA_BASE  = 16'hff60;
	localparam logic [15:0] COUNT_MAX  = 16'hffff;

	localparam int FLAG_DEPTH = 256;
	localparam int MAP_DEPTH  = 65536;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] cu;
	} entry_t;
endpackage

// ===== hw/rtl/euc_to_unicode_decoder.sv =====
// Table-driven EUC to Unicode decoder. One input item is taken every clock
// cycle unless a full queue stalls the front end: flag and map writes land
// in their tables at acceptance; text bytes pass a flag-table read, a
// classification stage, at most one map-table read, the queue and the output
// register. The map RAM port (one read per byte) and the back end (one result
// per cycle while out_ready holds) set the rate; a zero byte after a pending
// lead byte yields the mapped character, if the limit allows, and a terminator.
// Both tables come up undefined and must be written before use. The user must
// write the output limit only while the decoder is idle; nothing enforces it.
// Depends on e2u_pkg, e2u_front, e2u_queue, e2u_back.
`timescale 1ns / 1ps
`include "euc_to_unicode_decoder_defines.svh"
module euc_to_unicode_decoder import e2u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] out_limit,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [15:0] table_index,
	input  logic [15:0] table_value,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        last
);
	logic [15:0] limit_q;
	logic        q_full;
	logic        q_empty;
	logic        push;
	logic        pop;
	entry_t      push_entry;
	entry_t      head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 16'h0000;
		end else if (cfg_valid) begin
			limit_q <= out_limit;
		end
	end

	e2u_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.table_index (table_index),
		.table_value (table_value),
		.text_byte   (text_byte),
		.q_full      (q_full),
		.push        (push),
		.push_entry  (push_entry)
	);

	e2u_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	e2u_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit_q),
		.empty     (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.code_unit (code_unit),
		.last      (last)
	);

	`E2U_ASSERT(a_no_overflow, clk, arst_n, push, !q_full || pop)
	`E2U_ASSERT(a_no_underflow, clk, arst_n, pop, !q_empty)
	`E2U_ASSERT(a_term_zero, clk, arst_n, out_valid && last, code_unit == 16'h0000)
endmodule

// ===== hw/rtl/e2u_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module e2u_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== hw/rtl/e2u_front.sv =====
// Front end: accepts items, writes the tables, classifies text bytes and
// resolves map lookups. Depends on e2u_pkg and e2u_ram.
`timescale 1ns / 1ps
module e2u_front import e2u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [15:0] table_index,
	input  logic [15:0] table_value,
	input  logic [7:0]  text_byte,
	input  logic        q_full,
	output logic        push,
	output entry_t      push_entry
);
	logic        accept;
	logic        s1_adv;
	logic        s2_adv;
	logic        s1_valid_q;
	logic [7:0]  byte_s1;
	logic        flag_rdata;
	logic [15:0] map_rdata;
	logic        lead_waiting_q;
	logic [7:0]  lead_q;
	logic        cls_push;
	logic [1:0]  cls_kind;
	logic        cls_use_map;
	logic [15:0] cls_cu;
	logic [15:0] map_addr;
	logic        s2_valid_q;
	logic [1:0]  kind_s2;
	logic        use_map_s2;
	logic [15:0] cu_s2;

	assign s2_adv   = s2_valid_q && !q_full;
	assign s1_adv   = s1_valid_q && (!s2_valid_q || s2_adv);
	assign in_ready = !s1_valid_q || s1_adv;
	assign accept   = in_valid && in_ready;

	e2u_ram #(.WIDTH(1), .DEPTH(FLAG_DEPTH)) u_flag_ram (
		.clk   (clk),
		.we    (accept && operation == OP_FLAG),
		.waddr (table_index[7:0]),
		.wdata (table_value[0]),
		.re    (accept && operation == OP_DECODE),
		.raddr (text_byte),
		.rdata (flag_rdata)
	);

	e2u_ram #(.WIDTH(16), .DEPTH(MAP_DEPTH)) u_map_ram (
		.clk   (clk),
		.we    (accept && operation == OP_MAP),
		.waddr (table_index),
		.wdata (table_value),
		.re    (s1_adv && cls_use_map),
		.raddr (map_addr),
		.rdata (map_rdata)
	);

	always_comb begin
		cls_push    = 1'b1;
		cls_kind    = K_CHAR;
		cls_use_map = 1'b0;
		cls_cu      = {8'h00, byte_s1};
		map_addr    = {lead_q, byte_s1};
		if (byte_s1 == 8'h00) begin
			cls_kind    = lead_waiting_q ? K_TERM_MAP : K_TERM;
			cls_use_map = lead_waiting_q;
			cls_cu      = 16'h0000;
		end else if (lead_waiting_q) begin
			cls_use_map = 1'b1;
		end else if (flag_rdata) begin
			if (byte_s1 >= KANA_FIRST && byte_s1 < KANA_END) begin
				cls_cu = KANA_BASE + {8'h00, byte_s1 - KANA_FIRST};
			end
		end else begin
			cls_push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q     <= 1'b0;
			s2_valid_q     <= 1'b0;
			lead_waiting_q <= 1'b0;
			lead_q         <= 8'h00;
		end else begin
			if (accept && operation == OP_DECODE) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv && cls_push) begin
				s2_valid_q <= 1'b1;
			end else if (s2_adv) begin
				s2_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				if (byte_s1 == 8'h00 || lead_waiting_q) begin
					lead_waiting_q <= 1'b0;
				end else if (!flag_rdata) begin
					lead_waiting_q <= 1'b1;
					lead_q         <= byte_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_byte;
		end
		if (s1_adv) begin
			kind_s2    <= cls_kind;
			use_map_s2 <= cls_use_map;
			cu_s2      <= cls_cu;
		end
	end

	assign push            = s2_adv;
	assign push_entry.kind = kind_s2;
	assign push_entry.cu   = use_map_s2 ? map_rdata : cu_s2;
endmodule

// ===== hw/rtl/e2u_queue.sv =====
// Short FIFO of classified items between front and back end.
// Depends on e2u_pkg.
`timescale 1ns / 1ps
module e2u_queue import e2u_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);
	entry_t             slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q;
	logic [Q_PTR_W-1:0] rptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign full  = count_q == (Q_PTR_W + 1)'(Q_DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end
endmodule

// ===== hw/rtl/e2u_back.sv =====
// Back end: applies the output limit, counts characters, splits a pending
// lead plus terminator into at most two results. Depends on e2u_pkg.
`timescale 1ns / 1ps
module e2u_back import e2u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] limit,
	input  logic        empty,
	input  entry_t      head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        last
);
	logic        out_valid_q;
	logic        phase_q;
	logic [15:0] count_q;
	logic        can_load;
	logic        allowed;
	logic        emit;
	logic [15:0] emit_cu;
	logic        emit_last;
	logic        phase_d;
	logic [15:0] count_d;

	assign can_load = !out_valid_q || out_ready;
	assign allowed  = (limit == 16'h0000) || (count_q < limit);

	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		emit_cu   = 16'h0000;
		emit_last = 1'b0;
		phase_d   = phase_q;
		count_d   = count_q;
		if (!empty && can_load) begin
			case (head.kind)
				K_CHAR: begin
					pop = 1'b1;
					if (allowed) begin
						emit    = 1'b1;
						emit_cu = head.cu;
						count_d = (count_q == COUNT_MAX) ? count_q : count_q + 16'h0001;
					end
				end
				K_TERM: begin
					pop       = 1'b1;
					emit      = 1'b1;
					emit_last = 1'b1;
					count_d   = 16'h0000;
				end
				K_TERM_MAP: begin
					emit = 1'b1;
					if (!phase_q && allowed) begin
						emit_cu = head.cu;
						phase_d = 1'b1;
					end else begin
						pop       = 1'b1;
						emit_last = 1'b1;
						phase_d   = 1'b0;
						count_d   = 16'h0000;
					end
				end
				default: begin
					pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
			count_q     <= 16'h0000;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			code_unit <= emit_cu;
			last      <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
endmodule
